// File: rtl/u16550_pkg.sv
// Shared types and constants of the 16550-style UART register model.
package u16550_pkg;

  // Request kinds on the input channel; the fourth code means nothing.
  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_TICK  = 2'd2
  } op_t;

  // Register slots, word offsets from the base address.
  localparam logic [2:0] SLOT_RBR = 3'd0;  // RBR/THR, DLL under DLAB
  localparam logic [2:0] SLOT_IER = 3'd1;  // IER, DLM under DLAB
  localparam logic [2:0] SLOT_IIR = 3'd2;  // read IIR, write FCR
  localparam logic [2:0] SLOT_LCR = 3'd3;
  localparam logic [2:0] SLOT_MCR = 3'd4;
  localparam logic [2:0] SLOT_LSR = 3'd5;
  localparam logic [2:0] SLOT_MSR = 3'd6;
  localparam logic [2:0] SLOT_SCR = 3'd7;

  // Configuration register indexes.
  localparam logic CFG_RX_GAP_CYCLES = 1'b0;
  localparam logic CFG_UART_ENABLE   = 1'b1;

  localparam int unsigned LCR_DLAB = 7;
  localparam int unsigned LSR_DR   = 0;
  localparam int unsigned LSR_THRE = 5;

  localparam logic [7:0]  LSR_RESET    = 8'h60;
  localparam logic [7:0]  IIR_RESET    = 8'h01;
  localparam logic [23:0] RX_GAP_RESET = 24'd78125;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] address;
    logic [7:0]  write_data;
    logic        rx_valid;
    logic [7:0]  rx_byte;
    logic [23:0] elapsed_cycles;
    logic        irq_enable;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       passed_through;
    logic       rx_taken;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       irq;
  } result_t;

endpackage

// File: rtl/u16550_regfile.sv
// UART register state, bus decode and tick update for one request per cycle while step is high.
module u16550_regfile #(
  parameter logic [31:0] BASE_ADDRESS = 32'd268500992
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [23:0]         cfg_data,
  input  logic                step,
  input  u16550_pkg::item_t   item,
  output u16550_pkg::result_t result
);
  import u16550_pkg::*;

  logic [23:0] rx_gap_cycles_r;
  logic        uart_enable_r;

  logic [7:0]  rx_buffer_r,   rx_buffer_nxt;
  logic [7:0]  tx_holding_r,  tx_holding_nxt;
  logic [7:0]  dll_r,         dll_nxt;
  logic [7:0]  dlm_r,         dlm_nxt;
  logic [7:0]  ier_r,         ier_nxt;
  logic [7:0]  fcr_r,         fcr_nxt;
  logic [7:0]  lcr_r,         lcr_nxt;
  logic [7:0]  mcr_r,         mcr_nxt;
  logic [7:0]  lsr_r,         lsr_nxt;
  logic [7:0]  msr_r,         msr_nxt;
  logic [7:0]  scr_r,         scr_nxt;
  logic [23:0] rx_wait_r,     rx_wait_nxt;

  logic [31:0] offset;
  logic        hit;
  logic [2:0]  slot;
  logic        dlab;

  assign offset = {item.address[31:2], 2'b00} - BASE_ADDRESS;
  assign hit    = (offset[31:5] == '0) && (offset[1:0] == 2'b00);
  assign slot   = offset[4:2];
  assign dlab   = lcr_r[LCR_DLAB];

  always_comb begin
    rx_buffer_nxt  = rx_buffer_r;
    tx_holding_nxt = tx_holding_r;
    dll_nxt        = dll_r;
    dlm_nxt        = dlm_r;
    ier_nxt        = ier_r;
    fcr_nxt        = fcr_r;
    lcr_nxt        = lcr_r;
    mcr_nxt        = mcr_r;
    lsr_nxt        = lsr_r;
    msr_nxt        = msr_r;
    scr_nxt        = scr_r;
    rx_wait_nxt    = rx_wait_r;
    result         = '0;

    unique case (item.op)
      OP_READ: begin
        if (!hit) begin
          result.passed_through = 1'b1;
        end else begin
          unique case (slot)
            SLOT_RBR: begin
              if (dlab) begin
                result.read_data = dll_r;
              end else begin
                result.read_data  = rx_buffer_r;
                lsr_nxt[LSR_DR]   = 1'b0;
              end
            end
            SLOT_IER: begin
              if (dlab) begin
                // DLM read drops DR as well
                result.read_data  = dlm_r;
                lsr_nxt[LSR_DR]   = 1'b0;
              end else begin
                result.read_data = ier_r;
              end
            end
            SLOT_IIR: result.read_data = IIR_RESET;
            SLOT_LCR: result.read_data = lcr_r;
            SLOT_MCR: result.read_data = mcr_r;
            SLOT_LSR: result.read_data = lsr_r;
            SLOT_MSR: result.read_data = msr_r;
            SLOT_SCR: result.read_data = scr_r;
          endcase
        end
      end
      OP_WRITE: begin
        if (!hit) begin
          result.passed_through = 1'b1;
        end else begin
          unique case (slot)
            SLOT_RBR: begin
              if (dlab) begin
                dll_nxt = item.write_data;
              end else begin
                tx_holding_nxt    = item.write_data;
                lsr_nxt[LSR_THRE] = 1'b0;
              end
            end
            SLOT_IER: begin
              if (dlab) begin
                dlm_nxt = item.write_data;
              end else begin
                ier_nxt = item.write_data;
              end
            end
            SLOT_IIR: fcr_nxt = item.write_data;
            SLOT_LCR: lcr_nxt = item.write_data;
            SLOT_MCR: mcr_nxt = item.write_data;
            SLOT_LSR: lsr_nxt = item.write_data;
            SLOT_MSR: msr_nxt = item.write_data;
            SLOT_SCR: scr_nxt = item.write_data;
          endcase
        end
      end
      OP_TICK: begin
        if (uart_enable_r) begin
          // Count down the receive gap; a byte is latched only on a tick
          // that starts with the counter already at zero.
          if (rx_wait_r != '0) begin
            rx_wait_nxt = (item.elapsed_cycles > rx_wait_r) ? '0
                        : rx_wait_r - item.elapsed_cycles;
          end else if (item.rx_valid) begin
            rx_buffer_nxt   = item.rx_byte;
            lsr_nxt[LSR_DR] = 1'b1;
            rx_wait_nxt     = rx_gap_cycles_r;
            result.rx_taken = 1'b1;
          end
          if (!lsr_r[LSR_THRE]) begin
            result.tx_valid   = 1'b1;
            result.tx_byte    = tx_holding_r;
            tx_holding_nxt    = '0;
            lsr_nxt[LSR_THRE] = 1'b1;
          end
          result.irq = result.rx_taken & item.irq_enable;
        end
      end
      default: begin
        result = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_gap_cycles_r <= RX_GAP_RESET;
      uart_enable_r   <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RX_GAP_CYCLES: rx_gap_cycles_r <= cfg_data;
        CFG_UART_ENABLE:   uart_enable_r   <= cfg_data[0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_buffer_r  <= '0;
      tx_holding_r <= '0;
      dll_r        <= '0;
      dlm_r        <= '0;
      ier_r        <= '0;
      fcr_r        <= '0;
      lcr_r        <= '0;
      mcr_r        <= '0;
      lsr_r        <= LSR_RESET;
      msr_r        <= '0;
      scr_r        <= '0;
      rx_wait_r    <= '0;
    end else if (step) begin
      rx_buffer_r  <= rx_buffer_nxt;
      tx_holding_r <= tx_holding_nxt;
      dll_r        <= dll_nxt;
      dlm_r        <= dlm_nxt;
      ier_r        <= ier_nxt;
      fcr_r        <= fcr_nxt;
      lcr_r        <= lcr_nxt;
      mcr_r        <= mcr_nxt;
      lsr_r        <= lsr_nxt;
      msr_r        <= msr_nxt;
      scr_r        <= scr_nxt;
      rx_wait_r    <= rx_wait_nxt;
    end
  end

endmodule

// File: rtl/uart_16550_register_model.sv
// Top level: request register, UART register file and result register.
// One request (bus read, bus write or time tick) is accepted every cycle unless the output side stalls.
// A request lands in an input register, is evaluated against the UART
// register state in a single pass, and its result is captured in an output
// register when that register is empty or being drained; the state update
// takes effect as the request moves to the output register, so the next
// request sees it. The input side keeps accepting while a result waits, and
// stalls only when both the input and output registers are full.
// Configuration writes are taken in any cycle and should be issued only while
// no request is in flight.
module uart_16550_register_model #(
  parameter logic [31:0] BASE_ADDRESS = 32'd268500992
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [31:0] in_address,
  input  logic [7:0]  in_write_data,
  input  logic        in_rx_valid,
  input  logic [7:0]  in_rx_byte,
  input  logic [23:0] in_elapsed_cycles,
  input  logic        in_irq_enable,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_read_data,
  output logic        out_passed_through,
  output logic        out_rx_taken,
  output logic        out_tx_valid,
  output logic [7:0]  out_tx_byte,
  output logic        out_irq,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [23:0] cfg_data
);
  import u16550_pkg::*;

  item_t   req_r;
  logic    req_valid_r;
  result_t res_r;
  logic    res_valid_r;
  result_t res_nxt;
  logic    advance;

  assign advance   = req_valid_r && (!res_valid_r || out_ready);
  assign in_ready  = !req_valid_r || advance;
  assign cfg_ready = 1'b1;

  u16550_regfile #(
    .BASE_ADDRESS (BASE_ADDRESS)
  ) u_regfile (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (advance),
    .item      (req_r),
    .result    (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else if (in_ready) begin
      req_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r.op             <= in_op;
      req_r.address        <= in_address;
      req_r.write_data     <= in_write_data;
      req_r.rx_valid       <= in_rx_valid;
      req_r.rx_byte        <= in_rx_byte;
      req_r.elapsed_cycles <= in_elapsed_cycles;
      req_r.irq_enable     <= in_irq_enable;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (advance) begin
      res_valid_r <= 1'b1;
    end else if (out_ready) begin
      res_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid          = res_valid_r;
  assign out_read_data      = res_r.read_data;
  assign out_passed_through = res_r.passed_through;
  assign out_rx_taken       = res_r.rx_taken;
  assign out_tx_valid       = res_r.tx_valid;
  assign out_tx_byte        = res_r.tx_byte;
  assign out_irq            = res_r.irq;

  // Hold the input side when both registers are full and the result stalls.
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (req_valid_r && res_valid_r && !out_ready) |-> !in_ready)
    else $error("request accepted while both pipeline registers are full");

  a_miss_is_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_passed_through) |->
      (out_read_data == 8'd0 && !out_tx_valid && !out_rx_taken && !out_irq))
    else $error("passed-through request carries tick or read results");

  a_irq_needs_rx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_irq) |-> out_rx_taken)
    else $error("interrupt raised without a received byte");

  a_tx_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_tx_valid) |-> (out_tx_byte == 8'd0))
    else $error("transmit byte nonzero without a transmit");

endmodule

// File: sim/uart_16550_register_model_tb.sv
// Self-checking testbench for the 16550-style UART register model.
module uart_16550_register_model_tb;
  import u16550_pkg::*;

  class uart_shadow;
    logic [31:0] base;
    logic [23:0] rx_gap_cycles;
    logic        enabled;
    logic [7:0]  rbr, thr, dll, dlm, ier, iir, fcr, lcr, mcr, lsr, msr, scr;
    logic [23:0] rx_wait;
    result_t     awaited_results[$];
    int          errors;

    function new(logic [31:0] base_address);
      base = base_address;
      rx_gap_cycles = RX_GAP_RESET;
      enabled = 1'b1;
      {rbr, thr, dll, dlm, ier, fcr, lcr, mcr, msr, scr} = '0;
      iir = IIR_RESET;
      lsr = LSR_RESET;
      rx_wait = '0;
      errors = 0;
    endfunction

    function void set_config(logic index, logic [23:0] data);
      if (index == CFG_RX_GAP_CYCLES) rx_gap_cycles = data;
      else enabled = data[0];
    endfunction

    function int pending();
      return awaited_results.size();
    endfunction

    // Apply one accepted request to the shadow registers and queue its result.
    function void note_request(item_t it);
      result_t     r;
      logic [31:0] diff;
      logic [2:0]  slot;
      logic        hit;
      logic        dlab;
      logic        latched;
      r = '0;
      diff = (it.address & 32'hFFFF_FFFC) - base;
      hit = (diff < 32'd32) && (diff[1:0] == 2'b00);
      slot = diff[4:2];
      dlab = lcr[LCR_DLAB];
      latched = 1'b0;
      if (it.op == OP_READ) begin
        if (!hit) begin
          r.passed_through = 1'b1;
        end else begin
          case (slot)
            SLOT_RBR: if (dlab) begin
              r.read_data = dll;
            end else begin
              lsr[LSR_DR] = 1'b0;
              r.read_data = rbr;
            end
            SLOT_IER: if (dlab) begin
              lsr[LSR_DR] = 1'b0;
              r.read_data = dlm;
            end else begin
              r.read_data = ier;
            end
            SLOT_IIR: r.read_data = iir;
            SLOT_LCR: r.read_data = lcr;
            SLOT_MCR: r.read_data = mcr;
            SLOT_LSR: r.read_data = lsr;
            SLOT_MSR: r.read_data = msr;
            default:  r.read_data = scr;
          endcase
        end
      end else if (it.op == OP_WRITE) begin
        if (!hit) begin
          r.passed_through = 1'b1;
        end else begin
          case (slot)
            SLOT_RBR: if (dlab) begin
              dll = it.write_data;
            end else begin
              thr = it.write_data;
              lsr[LSR_THRE] = 1'b0;
            end
            SLOT_IER: if (dlab) dlm = it.write_data; else ier = it.write_data;
            SLOT_IIR: fcr = it.write_data;
            SLOT_LCR: lcr = it.write_data;
            SLOT_MCR: mcr = it.write_data;
            SLOT_LSR: lsr = it.write_data;
            SLOT_MSR: msr = it.write_data;
            default:  scr = it.write_data;
          endcase
        end
      end else if (it.op == OP_TICK && enabled) begin
        if (rx_wait != '0) begin
          rx_wait = (it.elapsed_cycles > rx_wait) ? '0 : rx_wait - it.elapsed_cycles;
        end else if (it.rx_valid) begin
          rbr = it.rx_byte;
          lsr[LSR_DR] = 1'b1;
          rx_wait = rx_gap_cycles;
          r.rx_taken = 1'b1;
          latched = 1'b1;
        end
        if (!lsr[LSR_THRE]) begin
          r.tx_valid = 1'b1;
          r.tx_byte = thr;
          thr = '0;
          lsr[LSR_THRE] = 1'b1;
        end
        r.irq = latched & it.irq_enable;
      end
      awaited_results.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t exp;
      if (awaited_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: rd=%h pt=%b", got.read_data,
                                   got.passed_through);
        return;
      end
      exp = awaited_results.pop_front();
      if (got.read_data !== exp.read_data || got.passed_through !== exp.passed_through ||
          got.rx_taken !== exp.rx_taken || got.tx_valid !== exp.tx_valid ||
          got.tx_byte !== exp.tx_byte || got.irq !== exp.irq) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch: exp rd=%h pt=%b rx=%b txv=%b txb=%h irq=%b",
                   exp.read_data, exp.passed_through, exp.rx_taken, exp.tx_valid,
                   exp.tx_byte, exp.irq);
          $display("          got rd=%h pt=%b rx=%b txv=%b txb=%h irq=%b",
                   got.read_data, got.passed_through, got.rx_taken, got.tx_valid,
                   got.tx_byte, got.irq);
        end
      end
    endfunction
  endclass

  localparam logic [31:0] UART_BASE = 32'd268500992;
  localparam logic [1:0]  OP_UNUSED = 2'd3;
  localparam int          IDLE_PCT  = 14;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_op = '0;
  logic [31:0] in_address = '0;
  logic [7:0]  in_write_data = '0;
  logic        in_rx_valid = 1'b0;
  logic [7:0]  in_rx_byte = '0;
  logic [23:0] in_elapsed_cycles = '0;
  logic        in_irq_enable = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_read_data;
  logic        out_passed_through;
  logic        out_rx_taken;
  logic        out_tx_valid;
  logic [7:0]  out_tx_byte;
  logic        out_irq;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [23:0] cfg_data = '0;

  uart_shadow sb;
  int         requests_sent = 0;
  bit         quiet_stretch = 1'b0;

  uart_16550_register_model #(.BASE_ADDRESS(UART_BASE)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_op(in_op), .in_address(in_address),
    .in_write_data(in_write_data), .in_rx_valid(in_rx_valid), .in_rx_byte(in_rx_byte),
    .in_elapsed_cycles(in_elapsed_cycles), .in_irq_enable(in_irq_enable),
    .out_valid(out_valid), .out_ready(out_ready), .out_read_data(out_read_data),
    .out_passed_through(out_passed_through), .out_rx_taken(out_rx_taken),
    .out_tx_valid(out_tx_valid), .out_tx_byte(out_tx_byte), .out_irq(out_irq),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [31:0] reg_addr(logic [2:0] slot, logic [1:0] low);
    return UART_BASE + {27'd0, slot, low};
  endfunction

  function automatic item_t make_req(logic [1:0] op, logic [31:0] addr, logic [7:0] data,
                                     logic rxv, logic [7:0] rxb, logic [23:0] el,
                                     logic irqen);
    item_t it;
    it.op = op;
    it.address = addr;
    it.write_data = data;
    it.rx_valid = rxv;
    it.rx_byte = rxb;
    it.elapsed_cycles = el;
    it.irq_enable = irqen;
    return it;
  endfunction

  function automatic item_t random_request();
    item_t it;
    int    pick;
    pick = $urandom_range(99);
    if (pick < 35) it.op = OP_READ;
    else if (pick < 65) it.op = OP_WRITE;
    else if (pick < 95) it.op = OP_TICK;
    else it.op = OP_UNUSED;
    pick = $urandom_range(99);
    if (pick < 85)
      it.address = reg_addr(3'($urandom_range(7)), 2'($urandom_range(3)));
    else if (pick < 92)
      it.address = $urandom_range(1) ? UART_BASE - 32'($urandom_range(1, 8))
                                     : UART_BASE + 32'($urandom_range(32, 40));
    else
      it.address = $urandom;
    it.write_data = 8'($urandom);
    it.rx_valid = ($urandom_range(99) < 70);
    it.rx_byte = 8'($urandom);
    pick = $urandom_range(99);
    if (pick < 25) it.elapsed_cycles = '0;
    else if (pick < 60) it.elapsed_cycles = 24'($urandom_range(255));
    else if (pick < 85) it.elapsed_cycles = 24'($urandom_range(100000));
    else it.elapsed_cycles = 24'($urandom);
    it.irq_enable = 1'($urandom);
    return it;
  endfunction

  // Hold the request until accepted; valid stays high if no gap follows.
  task automatic offer(item_t it);
    while (!quiet_stretch && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= it.op;
    in_address <= it.address;
    in_write_data <= it.write_data;
    in_rx_valid <= it.rx_valid;
    in_rx_byte <= it.rx_byte;
    in_elapsed_cycles <= it.elapsed_cycles;
    in_irq_enable <= it.irq_enable;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(it);
    requests_sent++;
  endtask

  // Drop valid and wait until every queued result has drained.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_config(logic index, logic [23:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_config(index, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_phase(logic [23:0] gap, logic en, int count, bit quiet);
    settle();
    write_config(CFG_RX_GAP_CYCLES, gap);
    write_config(CFG_UART_ENABLE, {23'($urandom), en});
    quiet_stretch = quiet;
    repeat (count) offer(random_request());
    quiet_stretch = 1'b0;
  endtask

  // Result side: check accepted results, stall at random, one long hold-off.
  initial begin : drain_results
    int hold_left;
    bit held_once;
    hold_left = 0;
    held_once = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready)
        sb.check_result('{out_read_data, out_passed_through, out_rx_taken,
                          out_tx_valid, out_tx_byte, out_irq});
      if (!held_once && requests_sent >= 1000) begin
        held_once = 1'b1;
        hold_left = 64;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= quiet_stretch ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  initial begin : watchdog
    #2000000;
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    sb = new(UART_BASE);
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset values, THR/tick handoff, DLAB latches, misses, unused op.
    offer(make_req(OP_READ, reg_addr(SLOT_LSR, 2'd0), '0, 1'b0, '0, '0, 1'b0));
    offer(make_req(OP_READ, reg_addr(SLOT_IIR, 2'd1), '0, 1'b0, '0, '0, 1'b0));
    offer(make_req(OP_WRITE, reg_addr(SLOT_RBR, 2'd3), 8'hFF, 1'b0, '0, '0, 1'b0));
    offer(make_req(OP_READ, reg_addr(SLOT_LSR, 2'd0), '0, 1'b0, '0, '0, 1'b0));
    offer(make_req(OP_TICK, '0, '0, 1'b1, 8'hA5, '0, 1'b1));
    offer(make_req(OP_READ, reg_addr(SLOT_RBR, 2'd0), '0, 1'b0, '0, '0, 1'b0));
    offer(make_req(OP_TICK, '0, '0, 1'b1, 8'h3C, 24'hFFFFFF, 1'b1));
    offer(make_req(OP_TICK, '0, '0, 1'b1, 8'h5A, '0, 1'b0));
    offer(make_req(OP_WRITE, reg_addr(SLOT_LCR, 2'd0), 8'h80, 1'b0, '0, '0, 1'b0));
    offer(make_req(OP_WRITE, reg_addr(SLOT_RBR, 2'd0), 8'h12, 1'b0, '0, '0, 1'b0));
    offer(make_req(OP_WRITE, reg_addr(SLOT_IER, 2'd0), 8'h34, 1'b0, '0, '0, 1'b0));
    offer(make_req(OP_READ, reg_addr(SLOT_RBR, 2'd0), '0, 1'b0, '0, '0, 1'b0));
    offer(make_req(OP_READ, reg_addr(SLOT_IER, 2'd2), '0, 1'b0, '0, '0, 1'b0));
    offer(make_req(OP_READ, reg_addr(SLOT_LSR, 2'd0), '0, 1'b0, '0, '0, 1'b0));
    offer(make_req(OP_WRITE, reg_addr(SLOT_LCR, 2'd0), 8'h03, 1'b0, '0, '0, 1'b0));
    offer(make_req(OP_WRITE, reg_addr(SLOT_IER, 2'd0), 8'hFF, 1'b0, '0, '0, 1'b0));
    offer(make_req(OP_WRITE, reg_addr(SLOT_IIR, 2'd0), 8'hC7, 1'b0, '0, '0, 1'b0));
    offer(make_req(OP_WRITE, reg_addr(SLOT_LSR, 2'd0), 8'h00, 1'b0, '0, '0, 1'b0));
    offer(make_req(OP_WRITE, reg_addr(SLOT_MSR, 2'd0), 8'hFF, 1'b0, '0, '0, 1'b0));
    offer(make_req(OP_WRITE, reg_addr(SLOT_SCR, 2'd0), 8'hAA, 1'b0, '0, '0, 1'b0));
    offer(make_req(OP_TICK, '0, '0, 1'b0, '0, 24'd1, 1'b1));
    offer(make_req(OP_READ, UART_BASE - 32'd4, '0, 1'b0, '0, '0, 1'b0));
    offer(make_req(OP_WRITE, UART_BASE + 32'd32, 8'h55, 1'b0, '0, '0, 1'b0));
    offer(make_req(OP_READ, 32'hFFFF_FFFF, '0, 1'b0, '0, '0, 1'b0));
    offer(make_req(OP_UNUSED, 32'hFFFF_FFFF, 8'hFF, 1'b1, 8'hFF, 24'hFFFFFF, 1'b1));

    run_phase(24'd0, 1'b1, 255, 1'b0);
    run_phase(24'($urandom_range(1, 300)), 1'b1, 255, 1'b0);
    run_phase(RX_GAP_RESET, 1'b1, 255, 1'b1);
    run_phase(24'hFFFFFF, 1'b1, 255, 1'b0);
    run_phase(24'($urandom), 1'b0, 255, 1'b0);
    run_phase(24'($urandom_range(1, 2000)), 1'b1, 255, 1'b0);

    settle();
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
